>>> design/blw_pkg.sv
// shared types and constants for the line pixel accumulator
`default_nettype none

package blw_pkg;

    localparam int COORD_BITS    = 12;
    localparam int PIXEL_BITS    = 16;
    localparam int SUM_BITS      = 29;
    localparam int CNT_BITS      = 13;
    localparam int ERR_BITS      = 14;
    localparam int KIND_BITS     = 2;
    localparam int IN_DATA_BITS  = 64;
    localparam int OUT_DATA_BITS = 72;

    // input word selector
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // result word kinds
    localparam logic [KIND_BITS-1:0] KIND_FETCH   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_FINAL   = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_IGNORED = 2'd2;

    typedef struct packed {
        logic                       busy;
        logic [COORD_BITS-1:0]      cur_x;
        logic [COORD_BITS-1:0]      cur_y;
        logic [COORD_BITS-1:0]      stop_x;
        logic [COORD_BITS-1:0]      stop_y;
        logic [COORD_BITS-1:0]      delta_x;
        logic [COORD_BITS-1:0]      delta_y;
        logic                       step_x_neg;
        logic                       step_y_neg;
        logic                       x_major;
        logic signed [ERR_BITS-1:0] err;
        logic                       extra;
        logic [SUM_BITS-1:0]        sum;
        logic [CNT_BITS-1:0]        cnt;
    } t_walk_state;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [COORD_BITS-1:0] fetch_x;
        logic [COORD_BITS-1:0] fetch_y;
        logic [SUM_BITS-1:0]   total_sum;
        logic [CNT_BITS-1:0]   sample_count;
        logic                  last;
    } t_result;

    function automatic logic [COORD_BITS-1:0] advance(input logic [COORD_BITS-1:0] v,
                                                      input logic neg);
        logic [COORD_BITS-1:0] inc;
        inc = neg ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
        return v + inc;
    endfunction

endpackage

`default_nettype wire

>>> design/dense_line_pixel_accumulator.sv
// top level: walk state registers, step logic and result register
// Takes one input word per cycle and returns exactly one result word for each. A load word
// answers with the first fetch coordinate (or a final word for a zero-length line); every
// returned pixel word answers with the next fetch coordinate, a densifying extra fetch, the
// final sum and count with tlast set, or an ignored word while idle. The step logic is
// combinational and its result is registered in the cycle after the word is taken, at one
// word per cycle; the input stalls only while the result register is full and not taken.
`default_nettype none

module dense_line_pixel_accumulator (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    // start_x, start_y, end_x, end_y, pixel_value
    input  wire logic [blw_pkg::IN_DATA_BITS-1:0]     i_s_tdata,
    // command
    input  wire logic                                 i_s_tuser,
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    // fetch_x, fetch_y, total_sum, sample_count, zero fill
    output logic [blw_pkg::OUT_DATA_BITS-1:0]         o_m_tdata,
    // kind
    output logic [blw_pkg::KIND_BITS-1:0]             o_m_tuser,
    output logic                                      o_m_tlast
);

    localparam int CW = blw_pkg::COORD_BITS;

    blw_pkg::t_walk_state r_state, n_state;
    blw_pkg::t_result     r_out, w_res;
    logic                 r_out_valid;
    logic                 in_acc;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign in_acc     = i_s_tvalid && o_s_tready;

    blw_step u_step (
        .i_state       (r_state),
        .i_command     (i_s_tuser),
        .i_start_x     (i_s_tdata[CW-1:0]),
        .i_start_y     (i_s_tdata[2*CW-1:CW]),
        .i_end_x       (i_s_tdata[3*CW-1:2*CW]),
        .i_end_y       (i_s_tdata[4*CW-1:3*CW]),
        .i_pixel_value ($signed(i_s_tdata[4*CW+blw_pkg::PIXEL_BITS-1:4*CW])),
        .o_state       (n_state),
        .o_result      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.last;
    assign o_m_tdata  = {{(blw_pkg::OUT_DATA_BITS - 2*CW - blw_pkg::SUM_BITS
                           - blw_pkg::CNT_BITS){1'b0}},
                         r_out.sample_count, r_out.total_sum, r_out.fetch_y, r_out.fetch_x};

    // an extra sample is only ever pending inside a walk
    a_extra_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.extra |-> r_state.busy)
        else $error("extra sample pending while idle");

    // final word ends the walk
    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && w_res.kind == blw_pkg::KIND_FINAL) |=> !r_state.busy)
        else $error("walk still busy after final word");

    // ignored words only come while idle
    a_ignored_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && w_res.kind == blw_pkg::KIND_IGNORED) |-> !r_state.busy)
        else $error("pixel ignored during a walk");

    // tlast marks exactly the final word
    a_last_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tuser == blw_pkg::KIND_FINAL)))
        else $error("tlast does not match final kind");

    // every pixel taken during a walk counts once
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_state.busy && i_s_tuser == blw_pkg::CMD_PIXEL)
        |=> r_state.cnt == blw_pkg::CNT_BITS'($past(r_state.cnt) + 1'b1))
        else $error("sample count did not advance");

endmodule

`default_nettype wire

>>> design/blw_step.sv
// one walk step: next state and result word for one accepted input word
`default_nettype none

module blw_step (
    input  wire blw_pkg::t_walk_state                   i_state,
    input  wire logic                                   i_command,
    input  wire logic [blw_pkg::COORD_BITS-1:0]         i_start_x,
    input  wire logic [blw_pkg::COORD_BITS-1:0]         i_start_y,
    input  wire logic [blw_pkg::COORD_BITS-1:0]         i_end_x,
    input  wire logic [blw_pkg::COORD_BITS-1:0]         i_end_y,
    input  wire logic signed [blw_pkg::PIXEL_BITS-1:0]  i_pixel_value,
    output blw_pkg::t_walk_state                        o_state,
    output blw_pkg::t_result                            o_result
);

    localparam int CW = blw_pkg::COORD_BITS;
    localparam int EW = blw_pkg::ERR_BITS;

    logic          ld_xneg, ld_yneg, ld_xmaj;
    logic [CW-1:0] ld_dx, ld_dy, ld_dmaj;
    logic          maj_neg, min_neg;
    logic [CW-1:0] maj_cur, min_cur, maj_stop, d_maj, d_min, maj_adv, min_adv;
    logic [CW-1:0] new_maj, new_min;
    logic signed [EW-1:0] e_add, new_err;
    logic          take_extra, done;

    always_comb begin
        // load decode
        ld_xneg = i_end_x < i_start_x;
        ld_yneg = i_end_y < i_start_y;
        ld_dx   = ld_xneg ? i_start_x - i_end_x : i_end_x - i_start_x;
        ld_dy   = ld_yneg ? i_start_y - i_end_y : i_end_y - i_start_y;
        ld_xmaj = ld_dx >= ld_dy;
        ld_dmaj = ld_xmaj ? ld_dx : ld_dy;

        // walk step expressed on major and minor axes
        maj_cur  = i_state.x_major ? i_state.cur_x      : i_state.cur_y;
        min_cur  = i_state.x_major ? i_state.cur_y      : i_state.cur_x;
        maj_stop = i_state.x_major ? i_state.stop_x     : i_state.stop_y;
        d_maj    = i_state.x_major ? i_state.delta_x    : i_state.delta_y;
        d_min    = i_state.x_major ? i_state.delta_y    : i_state.delta_x;
        maj_neg  = i_state.x_major ? i_state.step_x_neg : i_state.step_y_neg;
        min_neg  = i_state.x_major ? i_state.step_y_neg : i_state.step_x_neg;
        maj_adv  = blw_pkg::advance(maj_cur, maj_neg);
        min_adv  = blw_pkg::advance(min_cur, min_neg);

        e_add      = i_state.err + $signed({{(EW-CW){1'b0}}, d_min});
        new_err    = i_state.err;
        new_min    = min_cur;
        take_extra = 1'b0;
        if (!i_state.extra) begin
            new_err = e_add;
            if (e_add >= 0) begin
                new_min    = min_adv;
                new_err    = e_add - $signed({{(EW-CW){1'b0}}, d_maj});
                take_extra = maj_adv != maj_stop;
            end
        end
        new_maj = take_extra ? maj_cur : maj_adv;
        done    = !take_extra && (maj_adv == maj_stop);

        o_state  = i_state;
        o_result = '0;

        if (i_command == blw_pkg::CMD_LOAD) begin
            o_state.sum   = '0;
            o_state.cnt   = '0;
            o_state.extra = 1'b0;
            if (i_start_x == i_end_x && i_start_y == i_end_y) begin
                o_state.busy  = 1'b0;
                o_result.kind = blw_pkg::KIND_FINAL;
                o_result.last = 1'b1;
            end else begin
                o_state.step_x_neg = ld_xneg;
                o_state.step_y_neg = ld_yneg;
                o_state.delta_x    = ld_dx;
                o_state.delta_y    = ld_dy;
                o_state.x_major    = ld_xmaj;
                o_state.err        = EW'(0) - $signed({{(EW-CW){1'b0}}, ld_dmaj >> 1});
                o_state.cur_x      = i_start_x;
                o_state.cur_y      = i_start_y;
                o_state.stop_x     = i_end_x;
                o_state.stop_y     = i_end_y;
                o_state.busy       = 1'b1;
                o_result.kind      = blw_pkg::KIND_FETCH;
                o_result.fetch_x   = i_start_x;
                o_result.fetch_y   = i_start_y;
            end
        end else if (!i_state.busy) begin
            o_result.kind = blw_pkg::KIND_IGNORED;
        end else begin
            o_state.sum = i_state.sum + {{(blw_pkg::SUM_BITS-blw_pkg::PIXEL_BITS)
                                          {i_pixel_value[blw_pkg::PIXEL_BITS-1]}},
                                         i_pixel_value};
            o_state.cnt   = i_state.cnt + blw_pkg::CNT_BITS'(1);
            o_state.err   = new_err;
            o_state.extra = take_extra;
            o_state.cur_x = i_state.x_major ? new_maj : new_min;
            o_state.cur_y = i_state.x_major ? new_min : new_maj;
            if (done) begin
                o_state.busy          = 1'b0;
                o_result.kind         = blw_pkg::KIND_FINAL;
                o_result.total_sum    = o_state.sum;
                o_result.sample_count = o_state.cnt;
                o_result.last         = 1'b1;
            end else begin
                o_result.kind    = blw_pkg::KIND_FETCH;
                o_result.fetch_x = o_state.cur_x;
                o_result.fetch_y = o_state.cur_y;
            end
        end
    end

endmodule

`default_nettype wire

>>> verif/dense_line_pixel_accumulator_test.sv
// self-checking bench for the line pixel accumulator: directed lines, random walks, extremes
module dense_line_pixel_accumulator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS    = blw_pkg::COORD_BITS;
    localparam int PIXEL_BITS    = blw_pkg::PIXEL_BITS;
    localparam int SUM_BITS      = blw_pkg::SUM_BITS;
    localparam int CNT_BITS      = blw_pkg::CNT_BITS;
    localparam int KIND_BITS     = blw_pkg::KIND_BITS;
    localparam int IN_DATA_BITS  = blw_pkg::IN_DATA_BITS;
    localparam int OUT_DATA_BITS = blw_pkg::OUT_DATA_BITS;
    localparam logic CMD_LOAD    = blw_pkg::CMD_LOAD;
    localparam logic CMD_PIXEL   = blw_pkg::CMD_PIXEL;
    localparam logic [KIND_BITS-1:0] KIND_FETCH   = blw_pkg::KIND_FETCH;
    localparam logic [KIND_BITS-1:0] KIND_FINAL   = blw_pkg::KIND_FINAL;
    localparam logic [KIND_BITS-1:0] KIND_IGNORED = blw_pkg::KIND_IGNORED;

    typedef blw_pkg::t_result t_result;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int WALK_ITEMS  = 500;
    localparam int MAX_REPORTS = 100;
    localparam int SUM_LO      = 2 * COORD_BITS;
    localparam int CNT_LO      = SUM_LO + SUM_BITS;
    localparam logic [COORD_BITS-1:0] EDGE_HI = {COORD_BITS{1'b1}};

    typedef enum logic [1:0] {RX_STEADY, RX_CHOPPY, RX_STARVED} t_rx_mode;

    typedef struct packed {
        logic                  cmd;
        logic [COORD_BITS-1:0] sx, sy, ex, ey;
        logic [PIXEL_BITS-1:0] pix;
        logic                  typed;
        logic [KIND_BITS-1:0]  kind;
        logic                  last;
    } t_line_row;

    localparam int N_ROWS = 25;
    localparam t_line_row LINE_ROWS [N_ROWS] = '{
        // idle after reset, then zero-length lines at both corners
        '{CMD_PIXEL, 12'd0, 12'd0, 12'd0, 12'd0, 16'h7FFF, 1'b1, KIND_IGNORED, 1'b0},
        '{CMD_LOAD, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000, 1'b1, KIND_FINAL, 1'b1},
        '{CMD_LOAD, EDGE_HI, EDGE_HI, EDGE_HI, EDGE_HI, 16'hFFFF, 1'b1, KIND_FINAL, 1'b1},
        '{CMD_PIXEL, EDGE_HI, EDGE_HI, EDGE_HI, EDGE_HI, 16'h8000, 1'b1, KIND_IGNORED, 1'b0},
        // shallow line with one densifying sample
        '{CMD_LOAD, 12'd0, 12'd0, 12'd3, 12'd1, 16'h0000, 1'b0, KIND_FETCH, 1'b0},
        '{CMD_PIXEL, 12'd0, 12'd0, 12'd0, 12'd0, 16'h8000, 1'b0, KIND_FETCH, 1'b0},
        '{CMD_PIXEL, 12'd0, 12'd0, 12'd0, 12'd0, 16'h7FFF, 1'b0, KIND_FETCH, 1'b0},
        '{CMD_PIXEL, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000, 1'b0, KIND_FETCH, 1'b0},
        '{CMD_PIXEL, 12'd0, 12'd0, 12'd0, 12'd0, 16'hFFFF, 1'b0, KIND_FETCH, 1'b0},
        '{CMD_PIXEL, 12'd0, 12'd0, 12'd0, 12'd0, 16'h1234, 1'b1, KIND_IGNORED, 1'b0},
        // steep line walking down and left
        '{CMD_LOAD, EDGE_HI, EDGE_HI, 12'd4094, 12'd4092, 16'h0000, 1'b0, KIND_FETCH, 1'b0},
        '{CMD_PIXEL, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0001, 1'b0, KIND_FETCH, 1'b0},
        '{CMD_PIXEL, 12'd0, 12'd0, 12'd0, 12'd0, 16'h8000, 1'b0, KIND_FETCH, 1'b0},
        '{CMD_PIXEL, 12'd0, 12'd0, 12'd0, 12'd0, 16'h7FFF, 1'b0, KIND_FETCH, 1'b0},
        '{CMD_PIXEL, 12'd0, 12'd0, 12'd0, 12'd0, 16'h1234, 1'b0, KIND_FETCH, 1'b0},
        // horizontal and vertical lines
        '{CMD_LOAD, 12'd5, 12'd5, 12'd7, 12'd5, 16'h0000, 1'b0, KIND_FETCH, 1'b0},
        '{CMD_PIXEL, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0055, 1'b0, KIND_FETCH, 1'b0},
        '{CMD_PIXEL, 12'd0, 12'd0, 12'd0, 12'd0, 16'h00AA, 1'b0, KIND_FETCH, 1'b0},
        '{CMD_LOAD, 12'd9, 12'd0, 12'd9, 12'd2, 16'h0000, 1'b0, KIND_FETCH, 1'b0},
        '{CMD_PIXEL, 12'd0, 12'd0, 12'd0, 12'd0, 16'hFF00, 1'b0, KIND_FETCH, 1'b0},
        '{CMD_PIXEL, 12'd0, 12'd0, 12'd0, 12'd0, 16'h00FF, 1'b0, KIND_FETCH, 1'b0},
        // long line cut short by a new load
        '{CMD_LOAD, 12'd100, 12'd200, 12'd4000, 12'd3000, 16'h0000, 1'b0, KIND_FETCH, 1'b0},
        '{CMD_PIXEL, 12'd0, 12'd0, 12'd0, 12'd0, 16'h4000, 1'b0, KIND_FETCH, 1'b0},
        '{CMD_LOAD, EDGE_HI, 12'd0, 12'd0, EDGE_HI, 16'h0000, 1'b0, KIND_FETCH, 1'b0},
        '{CMD_PIXEL, 12'd0, 12'd0, 12'd0, 12'd0, 16'hC000, 1'b0, KIND_FETCH, 1'b0}
    };

    logic                     clk;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
    logic                     s_tuser  = CMD_LOAD;
    logic                     m_tready = 1'b0;
    logic                     s_tready;
    logic                     m_tvalid;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic [KIND_BITS-1:0]     m_tuser;
    logic                     m_tlast;

    // walk state mirrored by the predictor
    logic                  walk_busy;
    logic [COORD_BITS-1:0] walk_x, walk_y, stop_x, stop_y, span_x, span_y;
    logic                  neg_x, neg_y, along_x, extra_due;
    int                    walk_err;
    logic [SUM_BITS-1:0]   acc_sum;
    logic [CNT_BITS-1:0]   acc_cnt;

    t_result  walk_answers[$];
    int       mismatches;
    int       burst_left;
    int       walk_items;
    int       cycle_count;
    int       rx_left;
    t_rx_mode rx_mode;

    dense_line_pixel_accumulator i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [COORD_BITS-1:0] step_coord(input logic [COORD_BITS-1:0] v,
                                                         input logic neg);
        return neg ? v - 1'b1 : v + 1'b1;
    endfunction

    function automatic t_result fetch_at(input logic [COORD_BITS-1:0] x,
                                         input logic [COORD_BITS-1:0] y);
        t_result r;
        r = '0;
        r.kind    = KIND_FETCH;
        r.fetch_x = x;
        r.fetch_y = y;
        return r;
    endfunction

    // next result word of the walk for one accepted input word
    function automatic t_result walk_line_step(input logic cmd,
                                               input logic [IN_DATA_BITS-1:0] word);
        t_result               r;
        logic [COORD_BITS-1:0] x1, y1, x2, y2;
        logic [PIXEL_BITS-1:0] pix;
        logic                  near_end;
        r   = '0;
        x1  = word[0 +: COORD_BITS];
        y1  = word[COORD_BITS +: COORD_BITS];
        x2  = word[2*COORD_BITS +: COORD_BITS];
        y2  = word[3*COORD_BITS +: COORD_BITS];
        pix = word[4*COORD_BITS +: PIXEL_BITS];
        if (cmd == CMD_LOAD) begin
            acc_sum   = '0;
            acc_cnt   = '0;
            extra_due = 1'b0;
            if (x1 == x2 && y1 == y2) begin
                walk_busy = 1'b0;
                r.kind    = KIND_FINAL;
                r.last    = 1'b1;
                return r;
            end
            neg_x    = x2 < x1;
            neg_y    = y2 < y1;
            span_x   = neg_x ? x1 - x2 : x2 - x1;
            span_y   = neg_y ? y1 - y2 : y2 - y1;
            along_x  = span_x >= span_y;
            walk_err = along_x ? -int'(span_x >> 1) : -int'(span_y >> 1);
            walk_x   = x1;
            walk_y   = y1;
            stop_x   = x2;
            stop_y   = y2;
            walk_busy = 1'b1;
            return fetch_at(walk_x, walk_y);
        end
        if (!walk_busy) begin
            r.kind = KIND_IGNORED;
            return r;
        end
        acc_sum = acc_sum + {{(SUM_BITS-PIXEL_BITS){pix[PIXEL_BITS-1]}}, pix};
        acc_cnt = acc_cnt + 1'b1;
        if (!extra_due) begin
            walk_err += along_x ? int'(span_y) : int'(span_x);
            if (walk_err >= 0) begin
                if (along_x)
                    walk_y = step_coord(walk_y, neg_y);
                else
                    walk_x = step_coord(walk_x, neg_x);
                walk_err -= along_x ? int'(span_x) : int'(span_y);
                // minor step gets an extra sample unless the major axis is one short of the end
                near_end = along_x ? step_coord(walk_x, neg_x) == stop_x
                                   : step_coord(walk_y, neg_y) == stop_y;
                if (!near_end) begin
                    extra_due = 1'b1;
                    return fetch_at(walk_x, walk_y);
                end
            end
        end
        extra_due = 1'b0;
        if (along_x)
            walk_x = step_coord(walk_x, neg_x);
        else
            walk_y = step_coord(walk_y, neg_y);
        if (along_x ? walk_x == stop_x : walk_y == stop_y) begin
            walk_busy      = 1'b0;
            r.kind         = KIND_FINAL;
            r.total_sum    = acc_sum;
            r.sample_count = acc_cnt;
            r.last         = 1'b1;
            return r;
        end
        return fetch_at(walk_x, walk_y);
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] seen);
        if (want !== seen) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, seen);
        end
    endfunction

    task automatic send_word(input logic cmd, input logic [COORD_BITS-1:0] sx, sy, ex, ey,
                             input logic [PIXEL_BITS-1:0] pix, input logic typed,
                             input t_result typed_result);
        t_result predicted;
        int      gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {pix, ey, ex, sy, sx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predicted = walk_line_step(cmd, {pix, ey, ex, sy, sx});
        if (predicted.kind != KIND_IGNORED)
            walk_items++;
        walk_answers.push_back(typed ? typed_result : predicted);
    endtask

    function automatic logic [COORD_BITS-1:0] rand_coord();
        return COORD_BITS'($urandom_range(0, 4095));
    endfunction

    function automatic logic [COORD_BITS-1:0] coord_near(input logic [COORD_BITS-1:0] c,
                                                         input int reach);
        int lo, hi;
        lo = (int'(c) > reach) ? int'(c) - reach : 0;
        hi = (int'(c) + reach > 4095) ? 4095 : int'(c) + reach;
        return COORD_BITS'($urandom_range(lo, hi));
    endfunction

    function automatic logic [PIXEL_BITS-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return PIXEL_BITS'($urandom_range(0, 255));
            default: return PIXEL_BITS'($urandom());
        endcase
    endfunction

    task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix);
        send_word(CMD_PIXEL, rand_coord(), rand_coord(), rand_coord(), rand_coord(), pix,
                  1'b0, '0);
    endtask

    task automatic send_load(input logic [COORD_BITS-1:0] sx, sy, ex, ey);
        send_word(CMD_LOAD, sx, sy, ex, ey, rand_pixel(), 1'b0, '0);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (walk_answers.size() != 0) @(posedge clk);
        burst_left = 0;
    endtask

    // receiver stalls in stretches of steady, choppy and starved acceptance
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_left = $urandom_range(16, 200);
        end
        rx_left--;
        case (rx_mode)
            RX_STEADY:  m_tready <= 1'b1;
            RX_CHOPPY:  m_tready <= 1'($urandom_range(0, 1));
            default:    m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk) begin : result_check
        t_result seen, want;
        if (rst_n && m_tvalid && m_tready) begin
            seen.kind         = m_tuser;
            seen.fetch_x      = m_tdata[0 +: COORD_BITS];
            seen.fetch_y      = m_tdata[COORD_BITS +: COORD_BITS];
            seen.total_sum    = m_tdata[SUM_LO +: SUM_BITS];
            seen.sample_count = m_tdata[CNT_LO +: CNT_BITS];
            seen.last         = m_tlast;
            if (walk_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result word expected none actual kind %0d", $time,
                             seen.kind);
            end else begin
                want = walk_answers.pop_front();
                check_field("kind", 32'(want.kind), 32'(seen.kind));
                check_field("fetch_x", 32'(want.fetch_x), 32'(seen.fetch_x));
                check_field("fetch_y", 32'(want.fetch_y), 32'(seen.fetch_y));
                check_field("total_sum", 32'(want.total_sum), 32'(seen.total_sum));
                check_field("sample_count", 32'(want.sample_count), 32'(seen.sample_count));
                check_field("last", 32'(want.last), 32'(seen.last));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("dense_line_pixel_accumulator verification failed");
            $finish;
        end
    end

    initial begin
        t_result    typed_result;
        t_line_row  row;
        int         pick, reach, cut;
        logic [COORD_BITS-1:0] sx, sy;
        mismatches  = 0;
        burst_left  = 0;
        walk_items  = 0;
        cycle_count = 0;
        rx_left     = 0;
        rx_mode     = RX_STEADY;
        walk_busy   = 1'b0;
        extra_due   = 1'b0;
        walk_err    = 0;
        acc_sum     = '0;
        acc_cnt     = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++) begin
            row = LINE_ROWS[i];
            typed_result      = '0;
            typed_result.kind = row.kind;
            typed_result.last = row.last;
            send_word(row.cmd, row.sx, row.sy, row.ex, row.ey, row.pix, row.typed,
                      typed_result);
        end
        hold_until_drained();

        walk_items = 0;
        while (walk_items < WALK_ITEMS) begin
            if ($urandom_range(0, 99) < 6)
                hold_until_drained();
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                // short well-formed line walked to its end
                reach = ($urandom_range(0, 3) == 0) ? 40 : 6;
                sx = rand_coord();
                sy = rand_coord();
                send_load(sx, sy, coord_near(sx, reach), coord_near(sy, reach));
                while (walk_busy) send_pixel(rand_pixel());
            end else if (pick < 77) begin
                // long line abandoned part way
                send_load(rand_coord(), rand_coord(), rand_coord(), rand_coord());
                cut = $urandom_range(1, 30);
                while (walk_busy && cut > 0) begin
                    send_pixel(rand_pixel());
                    cut--;
                end
            end else if (pick < 87) begin
                sx = rand_coord();
                sy = rand_coord();
                send_load(sx, sy, sx, sy);
            end else begin
                repeat ($urandom_range(1, 3)) send_pixel(rand_pixel());
            end
        end

        // corner diagonals walked with the extreme pixel values
        send_load('0, '0, 12'd20, 12'd20);
        while (walk_busy) send_pixel(16'h7FFF);
        send_load('0, EDGE_HI, 12'd20, 12'd4075);
        while (walk_busy) send_pixel(16'h8000);

        s_tvalid <= 1'b0;
        while (walk_answers.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("dense_line_pixel_accumulator verification clean");
        else
            $display("dense_line_pixel_accumulator verification failed");
        $finish;
    end

endmodule
